### hw/rtl/hpd_pkg.sv
// Shared constants, types and codes of the half-tone pitch detector.
`timescale 1ns / 1ps
package hpd_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_SAMPLES_DEF = 2048;
  localparam int NUM_TONES_DEF      = 64;

  // Field widths fixed by the interface.
  localparam int SMP_W    = 16;
  localparam int TONE_W   = 6;
  localparam int PERIOD_W = 27;
  localparam int FRAC_W   = 16;
  localparam int IP_W     = PERIOD_W - FRAC_W;
  localparam int WEIGHT_W = 32;
  localparam int BEST_W   = 7;

  // Shared divider widths.
  localparam int NUM_W = 64;
  localparam int DEN_W = 48;

  // Score limits in Q2.30.
  localparam logic signed [WEIGHT_W-1:0] Q30_ONE      = 32'sd1073741824;
  localparam logic signed [WEIGHT_W:0]   SPREAD_LIMIT = 33'sd10737418;
  localparam logic [DEN_W-1:0]           DEN_OFFSET   = 48'd2147483648;

  // Request codes carried by req_type.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TABLE  = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_MIN_TONE = 1'b0;
  localparam logic CFG_MAX_TONE = 1'b1;

  // Control of the correlation pipeline.
  typedef struct packed {
    logic clr;   // clear both accumulators
    logic vld;   // read data arrives this cycle
    logic pair;  // the arriving data form a comparable pair
  } corr_ctrl_t;

endpackage

### hw/rtl/hpd_sample_mem.sv
// Sample window memory: one write port and two registered read ports.
`timescale 1ns / 1ps
module hpd_sample_mem import hpd_pkg::*; #(
  parameter int DEPTH = WINDOW_SAMPLES_DEF,
  parameter int AW    = $clog2(WINDOW_SAMPLES_DEF)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [SMP_W-1:0] wr_data,
  input  logic [AW-1:0]           rd_a_addr,
  input  logic [AW-1:0]           rd_b_addr,
  output logic signed [SMP_W-1:0] rd_a_data_r,
  output logic signed [SMP_W-1:0] rd_b_data_r
);

  logic signed [SMP_W-1:0] mem [DEPTH];

  // Write during loading, read both ports every cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data_r <= mem[rd_a_addr];
    rd_b_data_r <= mem[rd_b_addr];
  end

endmodule

### hw/rtl/hpd_period_mem.sv
// Period table memory: one write port and one registered read port.
`timescale 1ns / 1ps
module hpd_period_mem import hpd_pkg::*; #(
  parameter int DEPTH = NUM_TONES_DEF,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [PERIOD_W-1:0] wr_data,
  input  logic [AW-1:0]       rd_addr,
  output logic [PERIOD_W-1:0] rd_data_r
);

  logic [PERIOD_W-1:0] mem [DEPTH];

  // Table writes arrive as words; the analysis reads one entry per tone.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

### hw/rtl/hpd_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module hpd_div import hpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done_r,
  output logic [NUM_W-1:0] quo_r
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [DEN_W-1:0] rem_r, den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next numerator bit and try a subtraction.
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath needs no reset.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (busy_r) begin
      rem_r <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quo_r <= {quo_r[NUM_W-2:0], fits};
      cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

### hw/rtl/hpd_corr.sv
// Correlation pipeline: interpolates the shifted sample and sums AKF and AMDF terms.
`timescale 1ns / 1ps
module hpd_corr import hpd_pkg::*; #(
  parameter int SA_W = 60,
  parameter int SD_W = 45
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  corr_ctrl_t              ctrl,
  input  logic signed [SMP_W-1:0] xn,
  input  logic signed [SMP_W-1:0] xb,
  input  logic [FRAC_W:0]         lo,
  input  logic [FRAC_W-1:0]       frac,
  output logic signed [SA_W-1:0]  sa_r,
  output logic [SD_W-1:0]         sd_r,
  output logic                    busy
);

  logic signed [SMP_W-1:0] prev_r, xn1_r, xn2_r;
  logic signed [33:0]      m1_r, m2_r;
  logic signed [34:0]      xnt_r;
  logic signed [50:0]      prod_r;
  logic [32:0]             adiff_r;
  logic                    v1_r, v2_r, v3_r;
  logic signed [17:0]      lo_s;
  logic signed [16:0]      frac_s;
  logic signed [35:0]      diff;

  assign lo_s   = $signed({1'b0, lo});
  assign frac_s = $signed({1'b0, frac});
  assign diff   = $signed({xn2_r, 16'b0}) - xnt_r;
  assign busy   = v1_r | v2_r | v3_r;

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= ctrl.vld & ctrl.pair;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Stage one multiplies both neighbours by their interpolation weights.
  always_ff @(posedge clk) begin
    if (ctrl.vld) begin
      prev_r <= xb;
    end
    m1_r  <= prev_r * lo_s;
    m2_r  <= xb * frac_s;
    xn1_r <= xn;
    // Stage two forms the interpolated sample.
    xnt_r <= m1_r + m2_r;
    xn2_r <= xn1_r;
    // Stage three forms the product and the absolute difference.
    prod_r  <= xn2_r * xnt_r;
    adiff_r <= diff[35] ? 33'(-diff) : 33'(diff);
  end

  // Accumulators, cleared at the start of each tone.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sa_r <= '0;
      sd_r <= '0;
    end else if (v3_r) begin
      sa_r <= sa_r + SA_W'(prod_r);
      sd_r <= sd_r + SD_W'(adiff_r);
    end
  end

endmodule

### hw/rtl/halftone_pitch_detector.sv
// Top level of the half-tone pitch detector.
`timescale 1ns / 1ps
// Samples arrive as words on the input channel, one per cycle while in_stall
// is low, and are written to the window memory; period table entries arrive
// as words too. The sample word flagged last starts the analysis, during
// which in_stall stays high. Each tone from min_tone to max_tone then passes
// through a table read and check, a prime read and the paired reads from the
// dual-read window memory, the pipeline drain, three passes through the
// shared 64-bit divider and the hand-off of the result to the output
// register. Tones without comparable pairs skip the reads and the divisions.
// One result word per tone leaves through an output register; the last
// carries the best tone and the peak level. No clearing pass follows reset.
module halftone_pitch_detector import hpd_pkg::*; #(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
  parameter int NUM_TONES      = NUM_TONES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [TONE_W-1:0]          cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic signed [SMP_W-1:0]    in_sample_value,
  input  logic                       in_last_sample,
  input  logic [TONE_W-1:0]          in_entry_tone,
  input  logic [PERIOD_W-1:0]        in_entry_period,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [TONE_W-1:0]          out_tone_index,
  output logic signed [WEIGHT_W-1:0] out_weight,
  output logic                       out_degenerate,
  output logic                       out_final_result,
  output logic signed [BEST_W-1:0]   out_best_tone,
  output logic [SMP_W-1:0]           out_peak_level
);

  localparam int AW   = $clog2(WINDOW_SAMPLES);
  localparam int CW   = $clog2(WINDOW_SAMPLES + 1);
  localparam int TAW  = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam int SA_W = 48 + CW;
  localparam int SD_W = 33 + CW;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_TREAD = 10'b0000000010,
    S_TCHK  = 10'b0000000100,
    S_PRIME = 10'b0000001000,
    S_RUN   = 10'b0000010000,
    S_DRAIN = 10'b0000100000,
    S_DIV1  = 10'b0001000000,
    S_DIV2  = 10'b0010000000,
    S_DIV3  = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [TONE_W-1:0]          min_r, max_r, tone_r;
  logic [CW-1:0]              cnt_r, n_r, m_r;
  logic [SMP_W-1:0]           peak_r, peak_hold_r;
  logic                       tl_r, empty_r, degen_r, div_go_r;
  logic [IP_W-1:0]            ip_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [FRAC_W:0]            lo_r;
  logic [AW-1:0]              i_r;
  logic                       rd_vld_r, rd_pair_r;
  logic signed [WEIGHT_W-1:0] w_r, maxw_r, minw_r;
  logic signed [BEST_W-1:0]   best_r, best_fin;
  logic                       a_neg_r;
  logic [46:0]                a_mag_r;
  logic [32:0]                d_r;

  logic                    in_acc, smp_acc, tbl_acc, full, emit;
  logic [16:0]             mag;
  logic [SMP_W-1:0]        peak_upd;
  logic [PERIOD_W-1:0]     per_rd;
  logic [IP_W-1:0]         per_ip;
  logic                    tchk_degen;
  logic signed [SMP_W-1:0] rd_a, rd_b;
  logic [AW-1:0]           rd_a_addr, rd_b_addr;
  logic signed [SA_W-1:0]  sa;
  logic [SD_W-1:0]         sd;
  logic [SA_W-1:0]         sa_mag;
  logic                    corr_busy;
  corr_ctrl_t              corr_ctrl;
  logic                    div_done;
  logic [NUM_W-1:0]        div_num, div_quo;
  logic [DEN_W-1:0]        div_den;
  logic signed [WEIGHT_W-1:0] w_new;
  logic signed [WEIGHT_W:0]   spread;

  // Input handshake: words are taken only while loading.
  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid & ~in_stall;
  assign smp_acc  = in_acc & (in_req_type == REQ_SAMPLE);
  assign tbl_acc  = in_acc & (in_req_type == REQ_TABLE) &
                    (7'(in_entry_tone) < 7'(NUM_TONES));
  assign full     = (cnt_r == CW'(WINDOW_SAMPLES));
  assign mag      = in_sample_value[SMP_W-1] ? 17'(-18'(in_sample_value))
                                             : 17'(in_sample_value);
  assign peak_upd = (16'(mag) > peak_r) ? 16'(mag) : peak_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= '0;
      max_r <= 6'd47;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MIN_TONE: min_r <= cfg_data;
        CFG_MAX_TONE: max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Memories.
  hpd_sample_mem #(.DEPTH(WINDOW_SAMPLES), .AW(AW)) u_smem (
    .clk(clk), .wr_en(smp_acc & ~full), .wr_addr(cnt_r[AW-1:0]),
    .wr_data(in_sample_value), .rd_a_addr(rd_a_addr), .rd_b_addr(rd_b_addr),
    .rd_a_data_r(rd_a), .rd_b_data_r(rd_b)
  );

  hpd_period_mem #(.DEPTH(NUM_TONES), .AW(TAW)) u_pmem (
    .clk(clk), .wr_en(tbl_acc), .wr_addr(TAW'(in_entry_tone)),
    .wr_data(in_entry_period), .rd_addr(TAW'(tone_r)), .rd_data_r(per_rd)
  );

  // Read addresses: the prime read fetches s[ip], each pair then s[i] and s[i+ip+1].
  assign rd_a_addr = i_r;
  assign rd_b_addr = (state_r == S_PRIME) ? AW'(ip_r)
                                          : AW'(16'(i_r) + 16'(ip_r) + 16'd1);

  // Degenerate check on the freshly read period.
  assign per_ip     = per_rd[PERIOD_W-1:FRAC_W];
  assign tchk_degen = ~tl_r | (7'(tone_r) >= 7'(NUM_TONES)) |
                      (16'(n_r) < 16'(per_ip) + 16'd2);

  assign corr_ctrl.clr  = (state_r == S_TCHK);
  assign corr_ctrl.vld  = rd_vld_r;
  assign corr_ctrl.pair = rd_pair_r;

  hpd_corr #(.SA_W(SA_W), .SD_W(SD_W)) u_corr (
    .clk(clk), .rst_n(rst_n), .ctrl(corr_ctrl), .xn(rd_a), .xb(rd_b),
    .lo(lo_r), .frac(frac_r), .sa_r(sa), .sd_r(sd), .busy(corr_busy)
  );

  // Divider operands follow the division in progress.
  assign sa_mag = sa[SA_W-1] ? SA_W'(-sa) : SA_W'(sa);
  always_comb begin
    case (state_r)
      S_DIV1: begin
        div_num = NUM_W'(sa_mag);
        div_den = DEN_W'(n_r);
      end
      S_DIV2: begin
        div_num = NUM_W'(sd);
        div_den = DEN_W'(m_r);
      end
      default: begin
        div_num = NUM_W'({a_mag_r, 15'b0});
        div_den = DEN_W'(d_r) + DEN_OFFSET;
      end
    endcase
  end

  hpd_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .num(div_num), .den(div_den),
    .done_r(div_done), .quo_r(div_quo)
  );

  assign w_new = a_neg_r ? WEIGHT_W'(-div_quo[WEIGHT_W-1:0])
                         : WEIGHT_W'(div_quo[WEIGHT_W-1:0]);

  // Best tone survives only a large enough spread.
  assign spread   = (WEIGHT_W+1)'(maxw_r) - (WEIGHT_W+1)'(minw_r);
  assign best_fin = (spread > SPREAD_LIMIT) ? best_r : -7'sd1;

  assign emit = (state_r == S_EMIT) & (~out_valid | ~out_stall);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (smp_acc && in_last_sample) begin
          state_nxt = (max_r < min_r) ? S_EMIT : S_TREAD;
        end
      end
      S_TREAD: state_nxt = S_TCHK;
      S_TCHK:  state_nxt = tchk_degen ? S_EMIT : S_PRIME;
      S_PRIME: state_nxt = S_RUN;
      S_RUN: begin
        if (CW'(i_r) + CW'(1) == m_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld_r && !corr_busy) begin
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: if (div_done) state_nxt = S_DIV2;
      S_DIV2: if (div_done) state_nxt = S_DIV3;
      S_DIV3: if (div_done) state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit) begin
          state_nxt = (empty_r || tone_r == max_r) ? S_LOAD : S_TREAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      peak_r    <= '0;
      tl_r      <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_pair_r <= 1'b0;
      div_go_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= (state_r == S_PRIME) | (state_r == S_RUN);
      rd_pair_r <= (state_r == S_RUN);
      div_go_r  <= ((state_r == S_DRAIN) && (state_nxt == S_DIV1)) ||
                   (div_done && (state_r == S_DIV1 || state_r == S_DIV2));
      if (tbl_acc) begin
        tl_r <= 1'b1;
      end
      if (smp_acc) begin
        if (in_last_sample) begin
          cnt_r  <= '0;
          peak_r <= '0;
        end else if (!full) begin
          cnt_r  <= cnt_r + 1'b1;
          peak_r <= peak_upd;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-window and per-tone working registers.
  always_ff @(posedge clk) begin
    if (smp_acc && in_last_sample) begin
      n_r         <= full ? cnt_r : cnt_r + 1'b1;
      peak_hold_r <= full ? peak_r : peak_upd;
      tone_r      <= min_r;
      empty_r     <= (max_r < min_r);
      degen_r     <= 1'b1;
      w_r         <= '0;
      maxw_r      <= -Q30_ONE;
      minw_r      <= Q30_ONE;
      best_r      <= -7'sd1;
    end
    if (state_r == S_TCHK) begin
      degen_r <= tchk_degen;
      w_r     <= '0;
      ip_r    <= per_ip;
      frac_r  <= per_rd[FRAC_W-1:0];
      lo_r    <= 17'h10000 - 17'(per_rd[FRAC_W-1:0]);
      m_r     <= CW'(16'(n_r) - 16'(per_ip) - 16'd1);
      i_r     <= '0;
    end
    if (state_r == S_RUN) begin
      i_r <= i_r + 1'b1;
    end
    if (state_r == S_DIV1 && div_done) begin
      a_neg_r <= sa[SA_W-1];
      a_mag_r <= div_quo[46:0];
    end
    if (state_r == S_DIV2 && div_done) begin
      d_r <= div_quo[32:0];
    end
    if (state_r == S_DIV3 && div_done) begin
      w_r <= w_new;
      if (w_new > maxw_r) begin
        maxw_r <= w_new;
        best_r <= BEST_W'({1'b0, tone_r});
      end
      if (w_new < minw_r) begin
        minw_r <= w_new;
      end
    end
    if (emit && !empty_r && tone_r != max_r) begin
      tone_r <= tone_r + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_tone_index   <= tone_r;
      out_weight       <= w_r;
      out_degenerate   <= degen_r;
      out_final_result <= empty_r | (tone_r == max_r);
      out_best_tone    <= (empty_r || tone_r == max_r) ? best_fin : '0;
      out_peak_level   <= (empty_r || tone_r == max_r) ? peak_hold_r : '0;
    end
  end

  // The correlation pipeline has drained before a division starts.
  a_div_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> !corr_busy && !rd_vld_r)
    else $error("division started with pairs still in flight");

  // Intermediate results carry neither best tone nor peak.
  a_nonfinal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_result |-> out_best_tone == '0 && out_peak_level == '0)
    else $error("non-final result carries best tone or peak");

  // The last sample of a window stops further input.
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc && in_last_sample |=> in_stall)
    else $error("input taken after the last sample of a window");

  // A degenerate result always has a zero weight.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_weight == '0)
    else $error("degenerate result with nonzero weight");

endmodule
